[sv/ptns_pkg.sv]
// Shared types, widths and constants of the point table nearest-snap block.
package ptns_pkg;

   // table geometry
   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // field widths
   localparam int COORD_W  = 16;
   localparam int WORD_W   = 32;
   localparam int RADIUS_W = 16;
   localparam int POINT_W  = 2 * COORD_W;

   // stream widths
   localparam int REQ_TDATA_W = 64;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_PAD_W   = RSP_TDATA_W - (2 + POINT_W + WORD_W);

   // squared distance and root unit widths
   localparam int MULT_W     = COORD_W + 2;
   localparam int PROD_W     = 2 * MULT_W;
   localparam int SQ_W       = 2 * COORD_W + 2;
   localparam int ROOT_W     = SQ_W / 2;
   localparam int REM_W      = ROOT_W + 3;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int STEP_W     = $clog2(ROOT_STEPS);

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(5);

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_SET  = 2'd1,
      OP_GET  = 2'd2,
      OP_SNAP = 2'd3
   } opcode_type;

endpackage

[sv/ptns_isqrt.sv]
// Bit-serial integer square root, one root bit per cycle.
module ptns_isqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ptns_pkg::SQ_W-1:0] radicand,
   output logic                      done,
   output logic [ptns_pkg::ROOT_W-1:0] root
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [ptns_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [ptns_pkg::SQ_W-1:0]     rad_ff, rad_in;
   logic [ptns_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [ptns_pkg::ROOT_W-1:0]   root_ff, root_in;
   logic [ptns_pkg::REM_W-1:0]    rem_sh;
   logic [ptns_pkg::REM_W-1:0]    trial;

   // bring down two radicand bits, try the next root bit
   assign rem_sh = {rem_ff[ptns_pkg::REM_W-3:0], rad_ff[ptns_pkg::SQ_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[ptns_pkg::SQ_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ptns_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ptns_pkg::ROOT_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == ptns_pkg::STEP_W'(ptns_pkg::ROOT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[sv/point_table_nearest_snap.sv]
// Top level: point table with add, set, get and nearest-point snap.
//
// Items arrive on the req_ stream: tuser carries the opcode, tdata the
// coordinates and data word. Each item gives exactly one item on the rsp_
// stream. csr_ writes the snap radius; it is always ready, and it is to be
// written only while the block is idle, which the block does not enforce.
// One item is worked on at a time; req_tready is high only when idle.
// A lookup (add, set, get) reads the stored points in turn and stops on
// a match or at the end. A snap squares the offsets to every stored point
// and takes the root for each point that improves on the best so far,
// all behind one squaring multiplier and a bit-serial square root that
// delivers one root bit per cycle. The block is idle for the next item
// once the result is registered. Point and word tables each have a write
// and a read port and are read one entry per cycle.
// The result sits in an output register; the next item is accepted while
// it waits, and that item's result waits in turn until rsp_tready frees it.
// Synchronous reset empties the table, sets the radius to 5 and drops any
// pending result.
module point_table_nearest_snap (
   input  logic clock,
   input  logic reset,
   // req_tdata: coord_x[15:0], coord_y[31:16], data_in[63:32]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ptns_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_tuser: opcode[1:0]
   input  logic [ptns_pkg::REQ_TUSER_W-1:0]    req_tuser,
   // rsp_tdata: found[0], table_full[1], point_x[17:2], point_y[33:18],
   //            data_out[65:34], zero[71:66]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ptns_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // radius register write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ptns_pkg::RADIUS_W-1:0]       csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EVAL,
      ST_SQ_Y,
      ST_ROOT,
      ST_SQ_ROOT,
      ST_FINISH
   } state_type;

   localparam int CW = ptns_pkg::COORD_W;

   state_type                           state_ff, state_in;
   ptns_pkg::opcode_type                op_ff, op_in;
   logic [CW-1:0]                       qx_ff, qx_in;
   logic [CW-1:0]                       qy_ff, qy_in;
   logic [ptns_pkg::WORD_W-1:0]         qdata_ff, qdata_in;
   logic [ptns_pkg::RADIUS_W-1:0]       radius_ff, radius_in;
   logic [ptns_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [ptns_pkg::CNT_W-1:0]          scan_ff, scan_in;
   logic [ptns_pkg::SQ_W-1:0]           thresh_ff, thresh_in;
   logic [ptns_pkg::SQ_W-1:0]           sqx_ff, sqx_in;
   logic                                res_found_ff, res_found_in;
   logic                                res_full_ff, res_full_in;
   logic [CW-1:0]                       res_x_ff, res_x_in;
   logic [CW-1:0]                       res_y_ff, res_y_in;
   logic [ptns_pkg::WORD_W-1:0]         res_data_ff, res_data_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ptns_pkg::RSP_TDATA_W-1:0]    rsp_data_ff, rsp_data_in;

   // tables
   logic [ptns_pkg::POINT_W-1:0]        point_mem [ptns_pkg::MAX_POINTS];
   logic [ptns_pkg::WORD_W-1:0]         word_mem  [ptns_pkg::MAX_POINTS];
   logic [ptns_pkg::POINT_W-1:0]        point_rd_ff;
   logic [ptns_pkg::WORD_W-1:0]         word_rd_ff;
   logic                                point_we;
   logic                                word_we;
   logic [ptns_pkg::IDX_W-1:0]          word_wr_addr;
   logic [ptns_pkg::WORD_W-1:0]         word_wr_data;

   // shared squaring unit and root unit
   logic signed [ptns_pkg::MULT_W-1:0]  mult_op;
   logic signed [ptns_pkg::PROD_W-1:0]  prod;
   logic [ptns_pkg::SQ_W-1:0]           sq;
   logic [ptns_pkg::SQ_W-1:0]           d2;
   logic signed [ptns_pkg::MULT_W-1:0]  dx;
   logic signed [ptns_pkg::MULT_W-1:0]  dy;
   logic                                root_start;
   logic                                root_done;
   logic [ptns_pkg::ROOT_W-1:0]         root;
   logic                                hit;
   logic                                at_end;

   assign prod = mult_op * mult_op;
   assign sq   = prod[ptns_pkg::SQ_W-1:0];

   assign dx = {{2{point_rd_ff[CW-1]}}, point_rd_ff[CW-1:0]}
             - {{2{qx_ff[CW-1]}}, qx_ff};
   assign dy = {{2{point_rd_ff[2*CW-1]}}, point_rd_ff[2*CW-1:CW]}
             - {{2{qy_ff[CW-1]}}, qy_ff};
   assign d2 = sqx_ff + sq;

   assign hit    = (point_rd_ff == {qy_ff, qx_ff});
   assign at_end = (scan_ff == count_ff);

   ptns_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (d2),
      .done     (root_done),
      .root     (root)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      qdata_in     = qdata_ff;
      radius_in    = radius_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      thresh_in    = thresh_ff;
      sqx_in       = sqx_ff;
      res_found_in = res_found_ff;
      res_full_in  = res_full_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_data_in  = res_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      point_we     = 1'b0;
      word_we      = 1'b0;
      word_wr_addr = scan_ff[ptns_pkg::IDX_W-1:0];
      word_wr_data = qdata_ff;
      root_start   = 1'b0;
      mult_op      = '0;

      if (csr_valid) begin
         radius_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            // squared radius is the first threshold
            mult_op = {2'b00, radius_ff};
            if (req_tvalid) begin
               op_in        = ptns_pkg::opcode_type'(req_tuser[1:0]);
               qx_in        = req_tdata[CW-1:0];
               qy_in        = req_tdata[2*CW-1:CW];
               qdata_in     = req_tdata[2*CW +: ptns_pkg::WORD_W];
               thresh_in    = sq;
               scan_in      = '0;
               res_found_in = 1'b0;
               res_full_in  = 1'b0;
               res_x_in     = '0;
               res_y_in     = '0;
               res_data_in  = '0;
               state_in     = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (at_end) begin
               // no match in the table: append on add
               if (op_ff == ptns_pkg::OP_ADD) begin
                  if (count_ff == ptns_pkg::CNT_W'(ptns_pkg::MAX_POINTS)) begin
                     res_full_in = 1'b1;
                  end else begin
                     point_we     = 1'b1;
                     word_we      = 1'b1;
                     word_wr_addr = count_ff[ptns_pkg::IDX_W-1:0];
                     word_wr_data = '0;
                     count_in     = count_ff + 1'b1;
                     res_found_in = 1'b1;
                  end
               end
               state_in = ST_FINISH;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (op_ff == ptns_pkg::OP_SNAP) begin
               mult_op  = dx;
               sqx_in   = sq;
               state_in = ST_SQ_Y;
            end else if (hit) begin
               res_found_in = 1'b1;
               if (op_ff == ptns_pkg::OP_SET) begin
                  word_we = 1'b1;
               end
               if (op_ff == ptns_pkg::OP_GET) begin
                  res_data_in = word_rd_ff;
               end
               state_in = ST_FINISH;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_SQ_Y: begin
            // floor(sqrt(d2)) < best exactly when d2 < best squared
            mult_op = dy;
            if (d2 < thresh_ff) begin
               root_start   = 1'b1;
               res_found_in = 1'b1;
               res_x_in     = point_rd_ff[CW-1:0];
               res_y_in     = point_rd_ff[2*CW-1:CW];
               state_in     = ST_ROOT;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_SQ_ROOT;
            end
         end
         ST_SQ_ROOT: begin
            // new threshold is the square of the new best distance
            mult_op   = {1'b0, root};
            thresh_in = sq;
            scan_in   = scan_ff + 1'b1;
            state_in  = ST_FETCH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{ptns_pkg::RSP_PAD_W{1'b0}}, res_data_ff, res_y_ff,
                               res_x_ff, res_full_ff, res_found_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         radius_ff    <= ptns_pkg::RADIUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         radius_ff    <= radius_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      qdata_ff     <= qdata_in;
      scan_ff      <= scan_in;
      thresh_ff    <= thresh_in;
      sqx_ff       <= sqx_in;
      res_found_ff <= res_found_in;
      res_full_ff  <= res_full_in;
      res_x_ff     <= res_x_in;
      res_y_ff     <= res_y_in;
      res_data_ff  <= res_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // point table
   always_ff @(posedge clock) begin
      if (point_we) begin
         point_mem[count_ff[ptns_pkg::IDX_W-1:0]] <= {qy_ff, qx_ff};
      end
      point_rd_ff <= point_mem[scan_ff[ptns_pkg::IDX_W-1:0]];
   end

   // data word table
   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem[word_wr_addr] <= word_wr_data;
      end
      word_rd_ff <= word_mem[scan_ff[ptns_pkg::IDX_W-1:0]];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // an accepted item holds the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ptns: ready while an item is in work");

   // a dropped add never reports found
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("ptns: found and table_full together");

   // table fill stays in range and grows by at most one point per cycle
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= ptns_pkg::CNT_W'(ptns_pkg::MAX_POINTS))
      else $error("ptns: entry count beyond table size");

   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + 1'b1))
      else $error("ptns: entry count jumped");

   // the root unit only completes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == ST_ROOT))
      else $error("ptns: root done outside root wait");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the point table nearest-snap block.
`timescale 1ns / 100ps

import ptns_pkg::*;

// One expected reply, field by field
typedef struct {
   logic                 found;
   logic                 full;
   logic [COORD_W-1:0]   px;
   logic [COORD_W-1:0]   py;
   logic [WORD_W-1:0]    dout;
} snap_reply_t;

// Mirror of the point table; predicts one reply per accepted item
class point_table_scoreboard;
   logic [COORD_W-1:0] pt_x[MAX_POINTS];
   logic [COORD_W-1:0] pt_y[MAX_POINTS];
   logic [WORD_W-1:0]  pt_word[MAX_POINTS];
   int unsigned        n_points;
   logic [RADIUS_W-1:0] radius;
   snap_reply_t        expected_replies[$];
   int                 errors;

   function new();
      n_points = 0;
      radius   = RADIUS_RESET;
      errors   = 0;
      foreach (pt_word[i]) pt_word[i] = '0;
   endfunction

   function int slot_of(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      for (int i = 0; i < n_points; i++)
         if (pt_x[i] == x && pt_y[i] == y) return i;
      return -1;
   endfunction

   // floor of the square root, built one bit at a time from the top
   function longint unsigned floor_root(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int k = 17; k >= 0; k--) begin
         trial = root | (64'd1 << k);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function void note_request(opcode_type op, logic [COORD_W-1:0] x,
                              logic [COORD_W-1:0] y, logic [WORD_W-1:0] word);
      snap_reply_t     r;
      int              slot;
      int              dx;
      int              dy;
      longint unsigned best;
      longint unsigned root_dist;
      r = '{default: '0};
      slot = slot_of(x, y);
      case (op)
         OP_ADD: begin
            if (slot >= 0) begin
               r.found = 1'b1;
            end else if (n_points >= MAX_POINTS) begin
               r.full = 1'b1;
            end else begin
               pt_x[n_points]    = x;
               pt_y[n_points]    = y;
               pt_word[n_points] = '0;
               n_points++;
               r.found = 1'b1;
            end
         end
         OP_SET: begin
            if (slot >= 0) begin
               pt_word[slot] = word;
               r.found = 1'b1;
            end
         end
         OP_GET: begin
            if (slot >= 0) begin
               r.dout  = pt_word[slot];
               r.found = 1'b1;
            end
         end
         default: begin
            // strict improvement only, so the earliest point wins a tie
            best = radius;
            for (int i = 0; i < n_points; i++) begin
               dx   = int'($signed(pt_x[i])) - int'($signed(x));
               dy   = int'($signed(pt_y[i])) - int'($signed(y));
               root_dist = floor_root(longint'(dx) * longint'(dx)
                                      + longint'(dy) * longint'(dy));
               if (root_dist < best) begin
                  best    = root_dist;
                  r.px    = pt_x[i];
                  r.py    = pt_y[i];
                  r.found = 1'b1;
               end
            end
         end
      endcase
      expected_replies.push_back(r);
   endfunction

   function void compare_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   function void check_reply(logic [RSP_TDATA_W-1:0] d);
      snap_reply_t e;
      if (expected_replies.size() == 0) begin
         $display("%0t: reply with nothing outstanding: expected none, actual %h", $time, d);
         errors++;
         return;
      end
      e = expected_replies.pop_front();
      compare_field("found", e.found, d[0]);
      compare_field("table_full", e.full, d[1]);
      compare_field("point_x", e.px, d[17:2]);
      compare_field("point_y", e.py, d[33:18]);
      compare_field("data_out", e.dout, d[65:34]);
      compare_field("padding", '0, d[RSP_TDATA_W-1:66]);
   endfunction
endclass

module tb_top;

   localparam int WATCHDOG_LIMIT = 10000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int PHASE_ITEMS    = 97;

   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_BURSTY} ready_mode_t;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata;
   logic [REQ_TUSER_W-1:0]  req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [RADIUS_W-1:0]     csr_data;

   point_table_scoreboard   sb;
   logic [COORD_W-1:0]      centre_x;
   logic [COORD_W-1:0]      centre_y;
   int unsigned             quiet_cycles;
   ready_mode_t             ready_mode;
   int unsigned             mode_left;

   point_table_nearest_snap uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      mode_left  = 0;
      ready_mode = READY_ALWAYS;
      sb         = new();
   end

   always #2 clock = ~clock;

   // receiver: stall pattern switches at random among four modes
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_t'($urandom_range(0, 3));
         mode_left  = $urandom_range(16, 128);
      end
      mode_left--;
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= $urandom_range(0, 1);
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:      rsp_tready <= ((mode_left % 16) < 4);
      endcase
   end

   // reply checking
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_reply(rsp_tdata);
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("point_table_nearest_snap verification failed");
            $finish;
         end
      end
   end

   // present one item and hold it until accepted
   task automatic send_item(opcode_type op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [WORD_W-1:0] word);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {word, y, x};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, x, y, word);
   endtask

   task automatic pause_sender(int unsigned cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // hold off until every reply is back, then let the block settle
   task automatic drain_replies();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_radius(logic [RADIUS_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.radius = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // coordinates: stored points, jitter round them, a cluster, or anywhere
   task automatic pick_point(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
      int unsigned sel;
      int unsigned k;
      sel = $urandom_range(0, 99);
      if (sel < 55 && sb.n_points > 0) begin
         k = $urandom_range(0, sb.n_points - 1);
         x = sb.pt_x[k];
         y = sb.pt_y[k];
         if (sel >= 30) begin
            x = x + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
            y = y + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
         end
      end else if (sel < 85) begin
         x = centre_x + COORD_W'($urandom_range(0, 48)) - COORD_W'(24);
         y = centre_y + COORD_W'($urandom_range(0, 48)) - COORD_W'(24);
      end else begin
         x = COORD_W'($urandom);
         y = COORD_W'($urandom);
      end
   endtask

   task automatic run_phase(int unsigned n_items);
      opcode_type         op;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      int unsigned        burst_left;
      int unsigned        sel;
      // clusters sometimes sit on the coordinate extremes
      if ($urandom_range(0, 3) == 0) begin
         centre_x = $urandom_range(0, 1) ? 16'h7ff0 : 16'h8008;
         centre_y = $urandom_range(0, 1) ? 16'h7ff0 : 16'h8008;
      end else begin
         centre_x = COORD_W'($urandom);
         centre_y = COORD_W'($urandom);
      end
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < n_items; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 25)      op = OP_ADD;
         else if (sel < 45) op = OP_SET;
         else if (sel < 65) op = OP_GET;
         else               op = OP_SNAP;
         pick_point(x, y);
         send_item(op, x, y, $urandom);
         burst_left--;
         if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 10));
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   initial begin
      logic [RADIUS_W-1:0] phase_radius[7];
      phase_radius = '{16'd1, 16'hffff, 16'd5, 16'($urandom_range(2, 64)),
                       16'($urandom), 16'($urandom_range(6, 300)), 16'd0};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, duplicates, absent points, reset radius
      send_item(OP_GET, 16'd0, 16'd0, 32'd0);
      send_item(OP_SNAP, 16'd0, 16'd0, 32'd0);
      send_item(OP_SET, 16'd0, 16'd0, 32'h1234_5678);
      send_item(OP_ADD, 16'h8000, 16'h8000, 32'd0);
      send_item(OP_ADD, 16'h7fff, 16'h7fff, 32'd0);
      send_item(OP_ADD, 16'h7fff, 16'h7fff, 32'hffff_ffff);
      send_item(OP_SET, 16'h7fff, 16'h7fff, 32'h8000_0000);
      send_item(OP_GET, 16'h7fff, 16'h7fff, 32'd0);
      send_item(OP_GET, 16'h8000, 16'h7fff, 32'd0);
      send_item(OP_ADD, 16'd10, 16'd0, 32'd0);
      send_item(OP_ADD, 16'd0, 16'd10, 32'd0);
      send_item(OP_SNAP, 16'd5, 16'd5, 32'd0);
      send_item(OP_SNAP, 16'd12, 16'd0, 32'd0);
      send_item(OP_SET, 16'h8000, 16'h8000, 32'h7fff_ffff);
      send_item(OP_GET, 16'h8000, 16'h8000, 32'd0);
      drain_replies();

      // widest radius: ties go to the earliest point, far corners still snap
      write_radius(16'hffff);
      send_item(OP_SNAP, 16'd5, 16'd5, 32'd0);
      send_item(OP_SNAP, 16'h7fff, 16'h8000, 32'd0);
      send_item(OP_SNAP, 16'h8000, 16'h7fff, 32'd0);
      send_item(OP_ADD, 16'd1, 16'd1, 32'hffff_ffff);
      send_item(OP_GET, 16'd1, 16'd1, 32'd0);
      drain_replies();

      // zero radius never snaps
      write_radius(16'd0);
      send_item(OP_SNAP, 16'd10, 16'd0, 32'd0);
      send_item(OP_ADD, 16'hffff, 16'hffff, 32'd0);
      send_item(OP_SET, 16'hffff, 16'hffff, 32'hffff_ffff);
      send_item(OP_GET, 16'hffff, 16'hffff, 32'd0);
      drain_replies();

      // random phases, each under its own radius
      foreach (phase_radius[p]) begin
         write_radius(phase_radius[p]);
         run_phase(PHASE_ITEMS);
         drain_replies();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_replies.size() == 0) begin
         $display("point_table_nearest_snap verification clean");
      end else begin
         $display("point_table_nearest_snap verification failed");
      end
      $finish;
   end

endmodule
